FILE: rtl/bsfa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, action codes and helper widths for the bit store.
// No dependencies.
package bsfa_pkg;

    localparam int STORE_BYTES = 32;
    localparam int FIELD_BITS  = 32;

    localparam int STORE_BITS  = STORE_BYTES * 8;
    localparam int STORE_IDX_W = (STORE_BITS > 1) ? $clog2(STORE_BITS) : 1;
    localparam int CNT_W       = $clog2(FIELD_BITS + 1);

    localparam int ACTION_W = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int BYTES_W  = 6;
    localparam int LIMIT_W  = BYTES_W + 3;

    localparam logic [BYTES_W-1:0] BYTES_RESET = 6'd32;

    localparam logic [ACTION_W-1:0] ACT_SET_BIT    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR_BIT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INVERT_BIT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_BIT   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_WRITE_RNG  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ_RNG   = 3'd5;

endpackage

FILE: rtl/bsfa_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the bit store.
// Depends on bsfa_pkg.
interface bsfa_req_if
    import bsfa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position_a;
    logic [POS_W-1:0]    position_b;
    logic [VALUE_W-1:0]  write_value;

    modport source (output valid, action, position_a, position_b, write_value, input ready);
    modport sink   (input valid, action, position_a, position_b, write_value, output ready);
endinterface

interface bsfa_rsp_if
    import bsfa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] read_data;
    logic               rejected;

    modport source (output valid, read_data, rejected, input ready);
    modport sink   (input valid, read_data, rejected, output ready);
endinterface

FILE: rtl/bit_store_field_access.sv
`timescale 1ns / 1ps
// Bit-addressable store with single-bit and bit-range access, bit-serial datapath.
// Depends on bsfa_pkg and the channel interfaces in bsfa_ifs.sv.
//
// One request is taken at a time. A single-bit action goes from transfer through
// the run state to the done state, which posts the result; a range write or read
// loads the field, moves it one bit per cycle through a 32-bit shift register and
// then posts the result. Rejected requests and unknown actions go straight to the
// done state. The store is 256 flip-flops cleared at reset and is usable right
// after reset. The next request is taken once the current one has been posted to
// the output register, even if that result has not yet been taken downstream. The
// user must write bytes_reg via cfg_we/cfg_data only while idle; unchecked here.
module bit_store_field_access
    import bsfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [BYTES_W-1:0] cfg_data,
    bsfa_req_if.sink           req,
    bsfa_rsp_if.source         rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [BYTES_W-1:0] STORE_BYTES_C = BYTES_W'(STORE_BYTES);
    localparam logic [POS_W-1:0]   SPAN_MAX      = POS_W'(FIELD_BITS - 1);
    localparam logic [CNT_W-1:0]   FIELD_CNT     = CNT_W'(FIELD_BITS);

    logic [1:0]            state_reg, state_next;
    logic [ACTION_W-1:0]   act_reg, act_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic [FIELD_BITS-1:0] shift_reg, shift_next;
    logic                  rej_reg, rej_next;
    logic [STORE_BITS-1:0] store_reg, store_next;
    logic [BYTES_W-1:0]    bytes_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]    out_data_reg, out_data_next;
    logic                  out_rej_reg, out_rej_next;

    logic [BYTES_W-1:0]     bytes_used;
    logic [LIMIT_W-1:0]     limit;
    logic                   a_out, b_out, reject;
    logic [POS_W-1:0]       lo, hi, span;
    logic [CNT_W-1:0]       count;
    logic                   accept, single, ranged, active, cur_bit;
    logic [STORE_IDX_W-1:0] idx;
    logic                   out_free;

    assign bytes_used = (bytes_reg > STORE_BYTES_C) ? STORE_BYTES_C : bytes_reg;
    assign limit      = {bytes_used, 3'b000};
    assign a_out      = {1'b0, req.position_a} >= limit;
    assign b_out      = {1'b0, req.position_b} >= limit;
    assign single     = (req.action <= ACT_READ_BIT);
    assign ranged     = (req.action == ACT_WRITE_RNG) || (req.action == ACT_READ_RNG);
    assign reject     = (single && a_out) || (ranged && (a_out || b_out));
    assign lo         = (req.position_a < req.position_b) ? req.position_a : req.position_b;
    assign hi         = (req.position_a < req.position_b) ? req.position_b : req.position_a;
    assign span       = hi - lo;
    assign count      = (span >= SPAN_MAX) ? FIELD_CNT : CNT_W'(span) + CNT_W'(1);

    assign req.ready  = (state_reg == ST_IDLE);
    assign accept     = req.valid && req.ready;
    assign active     = (left_reg != '0);
    assign idx        = pos_reg[STORE_IDX_W-1:0];
    assign cur_bit    = store_reg[idx];
    assign out_free   = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.rejected  = out_rej_reg;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        step_next      = step_reg;
        shift_next     = shift_reg;
        rej_next       = rej_reg;
        store_next     = store_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        out_rej_next   = out_rej_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = req.action;
                    rej_next   = reject;
                    shift_next = '0;
                    if (single)
                    begin
                        pos_next  = req.position_a;
                        left_next = CNT_W'(1);
                        step_next = CNT_W'(1);
                    end
                    else
                    begin
                        pos_next  = lo;
                        left_next = count;
                        step_next = FIELD_CNT;
                    end
                    if (req.action == ACT_WRITE_RNG)
                    begin
                        shift_next = req.write_value[FIELD_BITS-1:0];
                    end
                    if (reject || !(single || ranged))
                    begin
                        shift_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                case (act_reg)
                    ACT_SET_BIT:    store_next[idx] = 1'b1;
                    ACT_CLEAR_BIT:  store_next[idx] = 1'b0;
                    ACT_INVERT_BIT: store_next[idx] = !cur_bit;
                    ACT_READ_BIT:   shift_next = FIELD_BITS'(cur_bit);
                    ACT_WRITE_RNG:
                    begin
                        if (active)
                        begin
                            store_next[idx] = shift_reg[0];
                        end
                        shift_next = shift_reg >> 1;
                    end
                    ACT_READ_RNG:
                    begin
                        shift_next = shift_reg >> 1;
                        shift_next[FIELD_BITS-1] = active && cur_bit;
                    end
                    default: shift_next = '0;
                endcase
                pos_next  = pos_reg + POS_W'(1);
                left_next = active ? left_reg - CNT_W'(1) : '0;
                step_next = step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = VALUE_W'(shift_reg);
                    out_rej_next   = rej_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            store_reg     <= '0;
            bytes_reg     <= BYTES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            store_reg     <= store_next;
            if (cfg_we)
            begin
                bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pos_reg      <= pos_next;
        left_reg     <= left_next;
        step_reg     <= step_next;
        shift_reg    <= shift_next;
        rej_reg      <= rej_next;
        out_data_reg <= out_data_next;
        out_rej_reg  <= out_rej_next;
    end

endmodule

FILE: rtl/bsfa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bit store, bound to the top level.
// Depends on bsfa_pkg and bit_store_field_access.
module bsfa_checker
    import bsfa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [VALUE_W-1:0] rsp_read_data,
    input logic               rsp_rejected
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_read_data) && $stable(rsp_rejected))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_rejected |-> rsp_read_data == '0)
        else $error("rejected request returned data");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

endmodule

bind bit_store_field_access bsfa_checker u_bsfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_rejected  (rsp.rejected)
);
